// ===== rtl/hpq_pkg.sv =====
// ----------------------------------------------------------------------------
// hpq_pkg: shared types and constants of the hierarchical priority queue
// Transaction structs, operation and status codes, datapath micro-ops.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int CAPACITY_DEF   = 4096;
	localparam int NUM_LEVELS_DEF = 256;
	localparam int POINT_BITS_DEF = 24;

	// level search: width of one first-stage group
	localparam int SRCH_GROUP = 16;

	localparam int FUNC_W  = 2;
	localparam int PTF_W   = 24;
	localparam int LVLF_W  = 8;
	localparam int OCC_W   = 13;
	localparam int STAT_W  = 2;

	localparam logic [FUNC_W-1:0] FN_PUSH  = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP   = 2'd1;
	localparam logic [FUNC_W-1:0] FN_FLUSH = 2'd2;
	// unassigned code, ignored by the queue
	localparam logic [FUNC_W-1:0] FN_RSVD  = 2'd3;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_LEVEL = 2'd3;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [PTF_W-1:0]  point;
		logic [LVLF_W-1:0] level;
	} hpq_in_t;

	typedef struct packed {
		logic [PTF_W-1:0]  popped_point;
		logic [PTF_W-1:0]  head_point;
		logic [LVLF_W-1:0] head_level;
		logic              is_empty;
		logic [OCC_W-1:0]  occupancy;
		logic [STAT_W-1:0] status;
	} hpq_out_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_ERR,
		OP_FLUSH,
		OP_PUSH_RD,
		OP_PUSH_CAP,
		OP_PUSH_FIRST,
		OP_PUSH_FRONT,
		OP_TAIL_RD_P,
		OP_TAIL_CAP,
		OP_LINK_RD_T,
		OP_LINK_E_WR,
		OP_LINK_T_WR,
		OP_PUSH_FIN,
		OP_POP_RD,
		OP_POP_CAP,
		OP_POP_FIN,
		OP_HEAD_RD,
		OP_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		dp_op_t            op;
		logic [STAT_W-1:0] st;
	} hpq_cmd_t;

	typedef struct packed {
		logic is_push;
		logic is_pop;
		logic is_flush;
		logic full;
		logic lv_bad;
		logic empty;
		logic lv_nonempty;
		logic found;
	} hpq_stat_t;

endpackage

// ===== rtl/hpq_ram.sv =====
// ----------------------------------------------------------------------------
// hpq_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/hpq_search.sv =====
// ----------------------------------------------------------------------------
// hpq_search: two-stage search over the level occupancy bits
// Finds the lowest set bit above a bound, or the highest below it.
// ----------------------------------------------------------------------------
module hpq_search
	import hpq_pkg::*;
#(
	parameter int NUM_LEVELS = NUM_LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [NUM_LEVELS-1:0]         vec,
	input  logic                          start,
	input  logic                          mode_high,
	input  logic [$clog2(NUM_LEVELS)-1:0] bound,
	output logic                          found,
	output logic [$clog2(NUM_LEVELS)-1:0] index
);

	localparam int LVW = $clog2(NUM_LEVELS);
	localparam int NG  = (NUM_LEVELS + SRCH_GROUP - 1) / SRCH_GROUP;
	localparam int GBW = $clog2(SRCH_GROUP);

	logic [NG*SRCH_GROUP-1:0] vec_p;
	logic [NG-1:0]            any_c;
	logic [GBW-1:0]           idx_c [NG];
	logic [NG-1:0]            any_s1;
	logic [GBW-1:0]           idx_s1 [NG];
	logic                     mode_s1;
	logic                     found_c;
	logic [LVW-1:0]           index_c;

	assign vec_p = (NG*SRCH_GROUP)'(vec);

	// stage 1: per-group masked priority pick
	always_comb begin
		logic hit;
		int   p;
		for (int g = 0; g < NG; g++) begin
			any_c[g] = 1'b0;
			idx_c[g] = '0;
			for (int i = 0; i < SRCH_GROUP; i++) begin
				p   = g*SRCH_GROUP + i;
				hit = vec_p[p] && (mode_high ? (p < int'(bound)) : (p > int'(bound)));
				if (hit && (mode_high || !any_c[g])) begin
					idx_c[g] = GBW'(i);
				end
				any_c[g] = any_c[g] | hit;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_s1 <= '0;
		end else if (start) begin
			any_s1 <= any_c;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			idx_s1  <= idx_c;
			mode_s1 <= mode_high;
		end
	end

	// stage 2: pick across groups
	always_comb begin
		found_c = 1'b0;
		index_c = '0;
		for (int g = 0; g < NG; g++) begin
			if (any_s1[g] && (mode_s1 || !found_c)) begin
				index_c = LVW'(g*SRCH_GROUP + int'(idx_s1[g]));
			end
			found_c = found_c | any_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found <= 1'b0;
		end else begin
			found <= found_c;
		end
	end

	always_ff @(posedge clk) begin
		index <= index_c;
	end

endmodule

// ===== rtl/hpq_datapath.sv =====
// ----------------------------------------------------------------------------
// hpq_datapath: storage and registers of the hierarchical priority queue
// Executes one micro-op per cycle from the controller.
// ----------------------------------------------------------------------------
module hpq_datapath
	import hpq_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int POINT_BITS = POINT_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  hpq_in_t   in_item,
	input  hpq_cmd_t  cmd,
	output hpq_stat_t stat,
	output hpq_out_t  out_item
);

	localparam int AW  = $clog2(CAPACITY);
	localparam int UW  = $clog2(CAPACITY + 1);
	localparam int LVW = $clog2(NUM_LEVELS);

	hpq_in_t                 in_q;
	logic [AW-1:0]           front_q, free_head_q, e_q, f_q, t_q, nf_q, nx_q, link_ra_q;
	logic [LVW-1:0]          cur_q;
	logic [UW-1:0]           used_q, wm_q;
	logic [NUM_LEVELS-1:0]   nonempty_q;
	logic                    hit_q;
	logic [POINT_BITS-1:0]   popped_q;
	logic [STAT_W-1:0]       status_q;
	hpq_out_t                out_q;

	logic [LVW-1:0]          lv_idx;
	logic [AW-1:0]           link_val;

	logic                    pt_we, pt_re;
	logic [POINT_BITS-1:0]   pt_rd;
	logic                    ln_we, ln_re;
	logic [AW-1:0]           ln_waddr, ln_wdata, ln_raddr, ln_rd;
	logic                    tl_we, tl_re;
	logic [LVW-1:0]          tl_raddr;
	logic [AW-1:0]           tl_rd;

	logic                    s_start, s_mode, s_found;
	logic [LVW-1:0]          s_bound, s_index;

	assign lv_idx = LVW'(in_q.level);

	// entries at or above the watermark were never allocated: link reads i+1
	assign link_val = ({1'b0, link_ra_q} >= wm_q) ?
		((link_ra_q == AW'(CAPACITY-1)) ? '0 : link_ra_q + AW'(1)) : ln_rd;

	always_comb begin
		stat.is_push     = (in_q.func == FN_PUSH);
		stat.is_pop      = (in_q.func == FN_POP);
		stat.is_flush    = (in_q.func == FN_FLUSH);
		stat.full        = (used_q >= UW'(CAPACITY));
		stat.lv_bad      = ({24'd0, in_q.level} >= 32'(NUM_LEVELS));
		stat.empty       = (used_q == '0);
		stat.lv_nonempty = nonempty_q[lv_idx];
		stat.found       = s_found;
	end

	// memory port steering
	assign pt_we = (cmd.op == OP_PUSH_RD);
	assign pt_re = (cmd.op == OP_POP_RD) || (cmd.op == OP_HEAD_RD);

	always_comb begin
		ln_re    = 1'b0;
		ln_raddr = front_q;
		ln_we    = 1'b0;
		ln_waddr = e_q;
		ln_wdata = '0;
		tl_re    = 1'b0;
		tl_raddr = cur_q;
		case (cmd.op)
			OP_PUSH_RD: begin
				ln_re    = 1'b1;
				ln_raddr = free_head_q;
				tl_re    = 1'b1;
				tl_raddr = lv_idx;
			end
			OP_POP_RD: begin
				ln_re = 1'b1;
				tl_re = 1'b1;
			end
			OP_LINK_RD_T: begin
				ln_re    = 1'b1;
				ln_raddr = t_q;
			end
			OP_TAIL_RD_P: begin
				tl_re    = 1'b1;
				tl_raddr = s_index;
			end
			OP_PUSH_FIRST: begin
				ln_we = 1'b1;
			end
			OP_PUSH_FRONT: begin
				ln_we    = 1'b1;
				ln_wdata = front_q;
			end
			OP_LINK_E_WR: begin
				ln_we    = 1'b1;
				ln_wdata = link_val;
			end
			OP_LINK_T_WR: begin
				ln_we    = 1'b1;
				ln_waddr = t_q;
				ln_wdata = e_q;
			end
			OP_POP_FIN: begin
				ln_we    = 1'b1;
				ln_waddr = f_q;
				ln_wdata = free_head_q;
			end
			default: begin
			end
		endcase
	end

	assign tl_we   = (cmd.op == OP_PUSH_FIN);
	assign s_start = (cmd.op == OP_PUSH_RD) || (cmd.op == OP_POP_RD);
	assign s_mode  = (cmd.op == OP_PUSH_RD);
	assign s_bound = (cmd.op == OP_PUSH_RD) ? lv_idx : cur_q;

	hpq_ram #(.WIDTH(POINT_BITS), .DEPTH(CAPACITY)) u_point_ram (
		.clk   (clk),
		.we    (pt_we),
		.waddr (free_head_q),
		.wdata (POINT_BITS'(in_q.point)),
		.re    (pt_re),
		.raddr (front_q),
		.rdata (pt_rd)
	);

	hpq_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_link_ram (
		.clk   (clk),
		.we    (ln_we),
		.waddr (ln_waddr),
		.wdata (ln_wdata),
		.re    (ln_re),
		.raddr (ln_raddr),
		.rdata (ln_rd)
	);

	hpq_ram #(.WIDTH(AW), .DEPTH(NUM_LEVELS)) u_tail_ram (
		.clk   (clk),
		.we    (tl_we),
		.waddr (lv_idx),
		.wdata (e_q),
		.re    (tl_re),
		.raddr (tl_raddr),
		.rdata (tl_rd)
	);

	hpq_search #(.NUM_LEVELS(NUM_LEVELS)) u_search (
		.clk       (clk),
		.arst_n    (arst_n),
		.vec       (nonempty_q),
		.start     (s_start),
		.mode_high (s_mode),
		.bound     (s_bound),
		.found     (s_found),
		.index     (s_index)
	);

	// queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			free_head_q <= '0;
			cur_q       <= '0;
			used_q      <= '0;
			wm_q        <= '0;
			nonempty_q  <= '0;
		end else begin
			case (cmd.op)
				OP_FLUSH: begin
					front_q     <= '0;
					free_head_q <= '0;
					cur_q       <= '0;
					used_q      <= '0;
					wm_q        <= '0;
					nonempty_q  <= '0;
				end
				OP_PUSH_FIRST, OP_PUSH_FRONT: begin
					front_q <= e_q;
					cur_q   <= lv_idx;
				end
				OP_PUSH_FIN: begin
					nonempty_q[lv_idx] <= 1'b1;
					free_head_q        <= nf_q;
					used_q             <= used_q + UW'(1);
					if ({1'b0, e_q} == wm_q) begin
						wm_q <= wm_q + UW'(1);
					end
				end
				OP_POP_FIN: begin
					free_head_q <= f_q;
					used_q      <= used_q - UW'(1);
					if (hit_q) begin
						nonempty_q[cur_q] <= 1'b0;
					end
					if (used_q == UW'(1)) begin
						front_q <= '0;
						cur_q   <= '0;
					end else begin
						front_q <= nx_q;
						if (hit_q) begin
							cur_q <= s_found ? s_index : '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		if (ln_re) begin
			link_ra_q <= ln_raddr;
		end
		case (cmd.op)
			OP_LOAD: begin
				in_q     <= in_item;
				popped_q <= '0;
				status_q <= ST_OK;
			end
			OP_ERR: begin
				status_q <= cmd.st;
			end
			OP_PUSH_RD: begin
				e_q <= free_head_q;
			end
			OP_PUSH_CAP: begin
				nf_q <= link_val;
				t_q  <= tl_rd;
			end
			OP_TAIL_CAP: begin
				t_q <= tl_rd;
			end
			OP_POP_RD: begin
				f_q <= front_q;
			end
			OP_POP_CAP: begin
				popped_q <= pt_rd;
				nx_q     <= link_val;
				hit_q    <= (tl_rd == f_q);
			end
			OP_OUT_LOAD: begin
				out_q.popped_point <= PTF_W'(popped_q);
				out_q.head_point   <= (used_q == '0) ? '0 : PTF_W'(pt_rd);
				out_q.head_level   <= (used_q == '0) ? '0 : LVLF_W'(cur_q);
				out_q.is_empty     <= (used_q == '0);
				out_q.occupancy    <= OCC_W'(used_q);
				out_q.status       <= status_q;
			end
			default: begin
			end
		endcase
	end

	assign out_item = out_q;

endmodule

// ===== rtl/hpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// hpq_ctrl: sequencer of the hierarchical priority queue
// Steps each transaction through its micro-ops and owns both handshakes.
// ----------------------------------------------------------------------------
module hpq_ctrl
	import hpq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  hpq_stat_t stat,
	output hpq_cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE      = 14'b00000000000001,
		S_DECODE    = 14'b00000000000010,
		S_PUSH_A    = 14'b00000000000100,
		S_PUSH_FIRST= 14'b00000000001000,
		S_PUSH_SRCH = 14'b00000000010000,
		S_PUSH_TCAP = 14'b00000000100000,
		S_PUSH_TRD  = 14'b00000001000000,
		S_PUSH_LCAP = 14'b00000010000000,
		S_PUSH_LNK  = 14'b00000100000000,
		S_PUSH_FIN  = 14'b00001000000000,
		S_POP_A     = 14'b00010000000000,
		S_POP_B     = 14'b00100000000000,
		S_HEAD      = 14'b01000000000000,
		S_OUT       = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d     = state_q;
		out_valid_d = out_valid_q && !out_ready;
		cmd.op      = OP_NONE;
		cmd.st      = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_HEAD;
				if (stat.is_push) begin
					if (stat.full) begin
						cmd.op = OP_ERR;
						cmd.st = ST_FULL;
					end else if (stat.lv_bad) begin
						cmd.op = OP_ERR;
						cmd.st = ST_LEVEL;
					end else begin
						cmd.op  = OP_PUSH_RD;
						state_d = S_PUSH_A;
					end
				end else if (stat.is_pop) begin
					if (stat.empty) begin
						cmd.op = OP_ERR;
						cmd.st = ST_EMPTY;
					end else begin
						cmd.op  = OP_POP_RD;
						state_d = S_POP_A;
					end
				end else if (stat.is_flush) begin
					cmd.op = OP_FLUSH;
				end
			end
			S_PUSH_A: begin
				cmd.op = OP_PUSH_CAP;
				if (stat.empty) begin
					state_d = S_PUSH_FIRST;
				end else if (stat.lv_nonempty) begin
					state_d = S_PUSH_TRD;
				end else begin
					state_d = S_PUSH_SRCH;
				end
			end
			S_PUSH_FIRST: begin
				cmd.op  = OP_PUSH_FIRST;
				state_d = S_PUSH_FIN;
			end
			S_PUSH_SRCH: begin
				if (stat.found) begin
					cmd.op  = OP_TAIL_RD_P;
					state_d = S_PUSH_TCAP;
				end else begin
					cmd.op  = OP_PUSH_FRONT;
					state_d = S_PUSH_FIN;
				end
			end
			S_PUSH_TCAP: begin
				cmd.op  = OP_TAIL_CAP;
				state_d = S_PUSH_TRD;
			end
			S_PUSH_TRD: begin
				cmd.op  = OP_LINK_RD_T;
				state_d = S_PUSH_LCAP;
			end
			S_PUSH_LCAP: begin
				cmd.op  = OP_LINK_E_WR;
				state_d = S_PUSH_LNK;
			end
			S_PUSH_LNK: begin
				cmd.op  = OP_LINK_T_WR;
				state_d = S_PUSH_FIN;
			end
			S_PUSH_FIN: begin
				cmd.op  = OP_PUSH_FIN;
				state_d = S_HEAD;
			end
			S_POP_A: begin
				cmd.op  = OP_POP_CAP;
				state_d = S_POP_B;
			end
			S_POP_B: begin
				cmd.op  = OP_POP_FIN;
				state_d = S_HEAD;
			end
			S_HEAD: begin
				cmd.op  = OP_HEAD_RD;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT_LOAD;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

// ===== rtl/hierarchical_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// hierarchical_priority_queue_top: watershed flooding queue
// Hierarchical queue of pixel indices with push, pop and flush.
// ----------------------------------------------------------------------------
// Each input transaction pushes a point at a level, pops the front point, or
// flushes the queue; exactly one result transaction follows for each. The
// lowest nonempty level is served first and points of one level leave in
// arrival order. One transaction is in flight at a time. A push places the
// first point, opens a new lowest level, or appends behind the tail of its own
// level or of a lower level found by the level search; a pop takes the front
// point; flush, errors and unknown codes skip to the head read. The steps
// follow dependent reads and writes on the one-read, one-write link memory and
// the two-stage level search. The result register is separate, so the next
// input is taken while a result still waits. There is no clearing pass after
// reset: a watermark of allocated entries stands in for the initial free chain.
// ----------------------------------------------------------------------------
module hierarchical_priority_queue_top
	import hpq_pkg::*;
#(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int NUM_LEVELS = NUM_LEVELS_DEF,
	parameter int POINT_BITS = POINT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hpq_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output hpq_out_t out_item
);

	// command and status between sequencer and datapath
	hpq_cmd_t  cmd;
	hpq_stat_t stat;

	hpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hpq_datapath #(
		.CAPACITY   (CAPACITY),
		.NUM_LEVELS (NUM_LEVELS),
		.POINT_BITS (POINT_BITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.stat     (stat),
		.out_item (out_item)
	);

endmodule

// ===== rtl/hpq_checker.sv =====
// ----------------------------------------------------------------------------
// hpq_checker: port-level checks of the hierarchical priority queue
// Input accept, result consistency and output hold, bound to the top level.
// ----------------------------------------------------------------------------
module hpq_checker
	import hpq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input logic     out_valid,
	input logic     out_ready,
	input hpq_out_t out_item
);

	// one transaction at a time: busy right after an accept
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted back to back");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.is_empty == (out_item.occupancy == '0))
		else $error("empty flag disagrees with occupancy");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.is_empty |->
			out_item.head_point == '0 && out_item.head_level == '0)
		else $error("empty queue shows a head");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_EMPTY |->
			out_item.is_empty && out_item.popped_point == '0)
		else $error("empty pop reported on nonempty queue");

endmodule

bind hierarchical_priority_queue_top hpq_checker u_hpq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);
